// File: design/thermadc_pkg.sv
// ---------------------------------------------------------------------------
// thermadc_pkg
// Shared constants, register map and fixed-point formats of the thermistor
// ADC to temperature converter.
// ---------------------------------------------------------------------------
package thermadc_pkg;

  // default converter resolution
  localparam int ADC_BITS_DEF = 12;

  // register file
  localparam int COEFF_W  = 32;
  localparam int SERIES_W = 16;
  localparam int LIMIT_W  = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFF_A     = 3'd0,
    CFG_COEFF_B     = 3'd1,
    CFG_COEFF_C     = 3'd2,
    CFG_SERIES_OHMS = 3'd3,
    CFG_RAIL_LIMIT  = 3'd4
  } cfg_idx_t;

  localparam logic [COEFF_W-1:0]  COEFF_A_RST = 32'd1406785475;
  localparam logic [COEFF_W-1:0]  COEFF_B_RST = 32'd290368173;
  localparam logic [COEFF_W-1:0]  COEFF_C_RST = 32'd150411;
  localparam logic [SERIES_W-1:0] SERIES_RST  = 16'd1200;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST   = 12'd3971;

  // fixed-point formats
  localparam int RQ_FRAC   = 16;   // resistance fraction bits
  localparam int LOG_FRAC  = 24;   // log fraction bits
  localparam int MANT_W    = 31;   // log2 mantissa, Q1.30
  localparam int LN2_FRAC  = 32;
  localparam logic [LN2_FRAC-1:0] LN2_Q32 = 32'd2977044472;
  localparam int DEN_FRAC  = 40;   // denominator fraction bits
  localparam int CENTI     = 100;

  // output range
  localparam int TEMP_W       = 18;
  localparam int KELVIN_CENTI = 27315;
  localparam int TEMP_MAX     = 99999;
  localparam int K_SAT        = TEMP_MAX + KELVIN_CENTI;

endpackage

// File: design/thermadc_div.sv
// ---------------------------------------------------------------------------
// thermadc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ---------------------------------------------------------------------------
module thermadc_div #(
  parameter int NUM_W  = 44,
  parameter int DEN_W  = 12,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  work_r [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  genvar i;
  generate
    for (i = 0; i < NUM_W; i++) begin : g_stage
      logic              vld_p;
      logic [DEN_W-1:0]  rem_p;
      logic [NUM_W-1:0]  work_p;
      logic [DEN_W-1:0]  den_p;
      logic [SIDE_W-1:0] side_p;
      logic [DEN_W:0]    shl;
      logic              ge;
      logic [DEN_W-1:0]  rem_nxt;
      logic [NUM_W-1:0]  work_nxt;

      if (i == 0) begin : g_first
        assign vld_p  = in_vld;
        assign rem_p  = '0;
        assign work_p = in_num;
        assign den_p  = in_den;
        assign side_p = in_side;
      end else begin : g_next
        assign vld_p  = vld_r[i-1];
        assign rem_p  = rem_r[i-1];
        assign work_p = work_r[i-1];
        assign den_p  = den_r[i-1];
        assign side_p = side_r[i-1];
      end

      // shift in next numerator bit, trial subtract
      always_comb begin
        shl      = {rem_p, work_p[NUM_W-1]};
        ge       = (shl >= {1'b0, den_p});
        rem_nxt  = ge ? DEN_W'(shl - {1'b0, den_p}) : shl[DEN_W-1:0];
        work_nxt = {work_p[NUM_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= vld_p;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i]  <= rem_nxt;
          work_r[i] <= work_nxt;
          den_r[i]  <= den_p;
          side_r[i] <= side_p;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[NUM_W-1];
  assign out_quo  = work_r[NUM_W-1];
  assign out_side = side_r[NUM_W-1];

endmodule

// File: design/thermistor_adc_to_temperature_core.sv
// ---------------------------------------------------------------------------
// thermistor_adc_to_temperature_core
// Steinhart-Hart conversion of a thermistor divider ADC code to centi-Celsius.
// ---------------------------------------------------------------------------
// Fully pipelined: one code is taken every cycle, the pipeline holding as a
// whole while the result port stalls. The depth is set mostly by the two
// bit-per-stage dividers (resistance, ADC_BITS + 32 stages; reciprocal, 49
// stages), six normalize stages and the 24 squaring stages of the log2 unit.
// A zero code, a code at or above rail_code_limit, or a resistance below
// one ohm gives fault = 1 and a temperature of zero. Coefficient writes are
// meant for an idle pipeline.
module thermistor_adc_to_temperature_core #(
  parameter int ADC_BITS = thermadc_pkg::ADC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // input stream; tdata: adc_code
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]       in_tdata,
  // result stream; tdata: temp_centi_celsius; tuser: fault
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,
  output logic [0:0]                          out_tuser,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [thermadc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [thermadc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW       = thermadc_pkg::COEFF_W;
  localparam int CMP_W    = (ADC_BITS > thermadc_pkg::LIMIT_W) ? ADC_BITS
                                                             : thermadc_pkg::LIMIT_W;
  localparam int PROD_W   = ADC_BITS + thermadc_pkg::SERIES_W;
  localparam int RQ_W     = PROD_W + thermadc_pkg::RQ_FRAC;
  localparam int NORM_LV  = $clog2(RQ_W);
  localparam int MW       = thermadc_pkg::MANT_W;
  localparam int LF       = thermadc_pkg::LOG_FRAC;
  localparam int LG_INT_W = $clog2(RQ_W - thermadc_pkg::RQ_FRAC);
  localparam int MSB_OFF  = RQ_W - 1 - thermadc_pkg::RQ_FRAC;
  localparam int L_W      = LG_INT_W + LF;
  localparam int L2_W     = 2 * L_W - LF;
  localparam int L3_W     = L2_W + L_W - LF;
  localparam int BL_W     = CW + L_W - LF;
  localparam int CH_W     = CW + L3_W - LF;
  localparam int D_W      = CH_W + 2;
  localparam int TW       = thermadc_pkg::TEMP_W;
  localparam logic [D_W-1:0] K_NUM = D_W'(thermadc_pkg::CENTI) << thermadc_pkg::DEN_FRAC;

  // configuration registers
  logic [CW-1:0]                     coeff_a_r, coeff_b_r, coeff_c_r;
  logic [thermadc_pkg::SERIES_W-1:0] series_r;
  logic [thermadc_pkg::LIMIT_W-1:0]  limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_a_r <= thermadc_pkg::COEFF_A_RST;
      coeff_b_r <= thermadc_pkg::COEFF_B_RST;
      coeff_c_r <= thermadc_pkg::COEFF_C_RST;
      series_r  <= thermadc_pkg::SERIES_RST;
      limit_r   <= thermadc_pkg::LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        thermadc_pkg::CFG_COEFF_A:     coeff_a_r <= cfg_wdata[CW-1:0];
        thermadc_pkg::CFG_COEFF_B:     coeff_b_r <= cfg_wdata[CW-1:0];
        thermadc_pkg::CFG_COEFF_C:     coeff_c_r <= cfg_wdata[CW-1:0];
        thermadc_pkg::CFG_SERIES_OHMS: series_r  <= cfg_wdata[thermadc_pkg::SERIES_W-1:0];
        thermadc_pkg::CFG_RAIL_LIMIT:  limit_r   <= cfg_wdata[thermadc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances when the output register is free
  logic pipe_en;
  logic out_vld_r;
  assign pipe_en   = !out_vld_r || out_tready;
  assign in_tready = pipe_en;

  // entry stage: fault check and divider numerator product
  logic [ADC_BITS-1:0] code;
  logic [ADC_BITS-1:0] code_inv;
  logic                ent_vld_r, ent_flt_r;
  logic [ADC_BITS-1:0] ent_code_r;
  logic [PROD_W-1:0]   ent_prod_r;

  assign code     = in_tdata[ADC_BITS-1:0];
  // full scale minus code
  assign code_inv = ~code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (pipe_en) begin
      ent_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ent_code_r <= code;
      ent_flt_r  <= (code == '0) || (CMP_W'(code) >= CMP_W'(limit_r));
      ent_prod_r <= PROD_W'(code_inv) * PROD_W'(series_r);
    end
  end

  // resistance divider, Q.16
  logic            d1_vld;
  logic [RQ_W-1:0] d1_quo;
  logic [0:0]      d1_flt;

  thermadc_div #(.NUM_W(RQ_W), .DEN_W(ADC_BITS), .SIDE_W(1)) u_div_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (ent_vld_r),
    .in_num   ({ent_prod_r, {thermadc_pkg::RQ_FRAC{1'b0}}}),
    .in_den   (ent_code_r),
    .in_side  (ent_flt_r),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_flt)
  );

  // normalize stages: leading-zero count, one shift level per stage
  logic               nrm_vld_r [NORM_LV];
  logic               nrm_flt_r [NORM_LV];
  logic [RQ_W-1:0]    nrm_val_r [NORM_LV];
  logic [NORM_LV-1:0] nrm_cnt_r [NORM_LV];

  genvar k;
  generate
    for (k = 0; k < NORM_LV; k++) begin : g_norm
      localparam int LV = NORM_LV - 1 - k;
      localparam int SH = 1 << LV;
      logic               vld_p, flt_p, zero;
      logic [RQ_W-1:0]    val_p;
      logic [NORM_LV-1:0] cnt_p, cnt_nxt;

      if (k == 0) begin : g_first
        assign vld_p = d1_vld;
        assign flt_p = d1_flt[0] || (d1_quo[RQ_W-1:thermadc_pkg::RQ_FRAC] == '0);
        assign val_p = d1_quo;
        assign cnt_p = '0;
      end else begin : g_next
        assign vld_p = nrm_vld_r[k-1];
        assign flt_p = nrm_flt_r[k-1];
        assign val_p = nrm_val_r[k-1];
        assign cnt_p = nrm_cnt_r[k-1];
      end

      always_comb begin
        zero        = (val_p[RQ_W-1 -: SH] == '0);
        cnt_nxt     = cnt_p;
        cnt_nxt[LV] = zero;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          nrm_vld_r[k] <= 1'b0;
        end else if (pipe_en) begin
          nrm_vld_r[k] <= vld_p;
        end
      end

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          nrm_flt_r[k] <= flt_p;
          nrm_val_r[k] <= zero ? (val_p << SH) : val_p;
          nrm_cnt_r[k] <= cnt_nxt;
        end
      end
    end
  endgenerate

  // log2 fraction: one squaring per stage
  logic                log_vld_r [LF];
  logic                log_flt_r [LF];
  logic [MW-1:0]       log_m_r   [LF];
  logic [LF-1:0]       log_frc_r [LF];
  logic [LG_INT_W-1:0] log_int_r [LF];

  genvar t;
  generate
    for (t = 0; t < LF; t++) begin : g_log
      logic                vld_p, flt_p, bit_nxt;
      logic [MW-1:0]       m_p, m_nxt;
      logic [LF-1:0]       frc_p;
      logic [LG_INT_W-1:0] int_p;
      logic [2*MW-1:0]     sq;
      logic [MW:0]         sq_hi;

      if (t == 0) begin : g_first
        assign vld_p = nrm_vld_r[NORM_LV-1];
        assign flt_p = nrm_flt_r[NORM_LV-1];
        assign m_p   = nrm_val_r[NORM_LV-1][RQ_W-1 -: MW];
        assign frc_p = '0;
        assign int_p = LG_INT_W'(MSB_OFF - int'(nrm_cnt_r[NORM_LV-1]));
      end else begin : g_next
        assign vld_p = log_vld_r[t-1];
        assign flt_p = log_flt_r[t-1];
        assign m_p   = log_m_r[t-1];
        assign frc_p = log_frc_r[t-1];
        assign int_p = log_int_r[t-1];
      end

      always_comb begin
        sq      = (2*MW)'(m_p) * (2*MW)'(m_p);
        sq_hi   = sq[2*MW-1 -: MW+1];
        bit_nxt = sq_hi[MW];
        m_nxt   = bit_nxt ? sq_hi[MW:1] : sq_hi[MW-1:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          log_vld_r[t] <= 1'b0;
        end else if (pipe_en) begin
          log_vld_r[t] <= vld_p;
        end
      end

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          log_flt_r[t] <= flt_p;
          log_m_r[t]   <= m_nxt;
          log_frc_r[t] <= {frc_p[LF-2:0], bit_nxt};
          log_int_r[t] <= int_p;
        end
      end
    end
  endgenerate

  // polynomial stages: ln, squares, products, sum
  logic [L_W-1:0]            lg;
  logic [L_W+LF+8-1:0]       ln_prod;
  logic [2*L_W-1:0]          l2_prod;
  logic [L2_W+L_W-1:0]       l3_prod;
  logic [CW+L_W-1:0]         bl_prod;
  logic [CH_W-1:0]           ch_prod;
  logic [CW+LF-1:0]          cl_prod;
  logic [D_W-1:0]            d_sum;

  logic sl_vld_r, sl2_vld_r, sl3_vld_r, sp_vld_r, sd_vld_r;
  logic sl_flt_r, sl2_flt_r, sl3_flt_r, sp_flt_r, sd_flt_r;
  logic [L_W-1:0]  sl_l1_r, sl2_l1_r;
  logic [L2_W-1:0] sl2_l2_r;
  logic [L3_W-1:0] sl3_l3_r;
  logic [BL_W-1:0] sl3_bl_r, sp_bl_r;
  logic [CH_W-1:0] sp_ch_r;
  logic [CW-1:0]   sp_cl_r;
  logic [D_W-1:0]  sd_d_r;

  always_comb begin
    lg      = {log_int_r[LF-1], log_frc_r[LF-1]};
    ln_prod = (L_W+LF+8)'(lg) * (L_W+LF+8)'(thermadc_pkg::LN2_Q32);
    l2_prod = (2*L_W)'(sl_l1_r) * (2*L_W)'(sl_l1_r);
    l3_prod = (L2_W+L_W)'(sl2_l2_r) * (L2_W+L_W)'(sl2_l1_r);
    bl_prod = (CW+L_W)'(coeff_b_r) * (CW+L_W)'(sl2_l1_r);
    ch_prod = CH_W'(coeff_c_r) * CH_W'(sl3_l3_r[L3_W-1:LF]);
    cl_prod = (CW+LF)'(coeff_c_r) * (CW+LF)'(sl3_l3_r[LF-1:0]);
    d_sum   = D_W'(coeff_a_r) + D_W'(sp_bl_r) + D_W'(sp_ch_r) + D_W'(sp_cl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_vld_r  <= 1'b0;
      sl2_vld_r <= 1'b0;
      sl3_vld_r <= 1'b0;
      sp_vld_r  <= 1'b0;
      sd_vld_r  <= 1'b0;
    end else if (pipe_en) begin
      sl_vld_r  <= log_vld_r[LF-1];
      sl2_vld_r <= sl_vld_r;
      sl3_vld_r <= sl2_vld_r;
      sp_vld_r  <= sl3_vld_r;
      sd_vld_r  <= sp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sl_flt_r  <= log_flt_r[LF-1];
      sl_l1_r   <= ln_prod[L_W+LF+8-1:thermadc_pkg::LN2_FRAC];
      sl2_flt_r <= sl_flt_r;
      sl2_l1_r  <= sl_l1_r;
      sl2_l2_r  <= l2_prod[2*L_W-1:LF];
      sl3_flt_r <= sl2_flt_r;
      sl3_l3_r  <= l3_prod[L2_W+L_W-1:LF];
      sl3_bl_r  <= bl_prod[CW+L_W-1:LF];
      sp_flt_r  <= sl3_flt_r;
      sp_bl_r   <= sl3_bl_r;
      sp_ch_r   <= ch_prod;
      sp_cl_r   <= cl_prod[CW+LF-1:LF];
      sd_flt_r  <= sp_flt_r;
      sd_d_r    <= d_sum;
    end
  end

  // reciprocal divider, centi-kelvin rounded half up
  logic           d2_vld;
  logic [D_W-1:0] d2_quo;
  logic [0:0]     d2_flt;

  thermadc_div #(.NUM_W(D_W), .DEN_W(D_W), .SIDE_W(1)) u_div_k (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (sd_vld_r),
    .in_num   (K_NUM + (sd_d_r >> 1)),
    .in_den   (sd_d_r),
    .in_side  (sd_flt_r),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_flt)
  );

  // output register: offset to Celsius, saturate, fault forcing
  logic [TW-1:0] temp_nxt;
  logic [TW-1:0] out_temp_r;
  logic          out_flt_r;

  always_comb begin
    if (d2_flt[0]) begin
      temp_nxt = '0;
    end else if (d2_quo >= D_W'(thermadc_pkg::K_SAT)) begin
      temp_nxt = TW'(thermadc_pkg::TEMP_MAX);
    end else begin
      temp_nxt = TW'(d2_quo) - TW'(thermadc_pkg::KELVIN_CENTI);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_temp_r <= temp_nxt;
      out_flt_r  <= d2_flt[0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(24-TW){1'b0}}, out_temp_r};
  assign out_tuser  = out_flt_r;

  // checks
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_flt_r |-> out_temp_r == '0)
    else $error("fault result with nonzero temperature");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_flt_r |->
      ($signed(out_temp_r) <= $signed(TW'(thermadc_pkg::TEMP_MAX))) &&
      ($signed(out_temp_r) >= -$signed(TW'(thermadc_pkg::KELVIN_CENTI))))
    else $error("temperature outside saturation range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(ent_vld_r) && $stable(sd_vld_r) && $stable(d2_vld))
    else $error("pipeline moved while stalled");

endmodule
